### rtl/dscc_pkg.sv
// Package for the sectored cache controller: geometry constants, result codes and
// index-width helpers; the row layout is defined in the top level. No dependencies.
package dscc_pkg;

  localparam int unsigned DefNumSets       = 64;
  localparam int unsigned DefNumWays       = 4;
  localparam int unsigned DefTagsPerWay    = 2;
  localparam int unsigned DefSectorsPerWay = 4;
  localparam int unsigned DefBlockBytes    = 32;
  localparam int unsigned DefAddrWidth     = 32;

  // result kinds
  localparam logic [1:0] KindHit  = 2'd0;
  localparam logic [1:0] KindFill = 2'd1;
  localparam logic [1:0] KindWb   = 2'd2;

  // miss classes
  localparam logic [1:0] ClassNone   = 2'd0;
  localparam logic [1:0] ClassBlock  = 2'd1;
  localparam logic [1:0] ClassSector = 2'd2;

  // bit width of an index into n things, at least 1
  function automatic int unsigned idx_w(input int unsigned n);
    int unsigned b;
    b = 0;
    while ((1 << b) < n) b++;
    return (b == 0) ? 1 : b;
  endfunction

  // number of address bits a field of n values takes, 0 for n == 1
  function automatic int unsigned fld_w(input int unsigned n);
    int unsigned b;
    b = 0;
    while ((1 << b) < n) b++;
    return b;
  endfunction

endpackage

### rtl/dscc_set_mem.sv
// Set memory: one row per set, holding all ways' tags, sector bits and LRU ages.
// Synchronous, one write port and one registered read port. Depends on dscc_pkg.
module dscc_set_mem
  import dscc_pkg::*;
#(
  parameter int unsigned Depth = DefNumSets,
  parameter int unsigned Width = 8
) (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [idx_w(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]       rd_data_o,
  input  logic                   wr_en_i,
  input  logic [idx_w(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]       wr_data_i
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

### rtl/decoupled_sectored_cache_controller_unit.sv
// Top level of the sectored cache controller: request sequencer around dscc_set_mem.
// Depends on dscc_pkg and dscc_set_mem.
//
//  channel  | dir | tdata (low bit up)               | tuser       | tlast
//  s_axis   | in  | address[31:0]                    | mode        | -
//  m_axis   | out | request_address[31:0]            | kind,class  | last
//
// An access on a hit or on a miss with a usable way passes through accept and memory
// read, decide, then write back the row and load the result. An eviction first walks
// every sector of the victim way in turn, dirty or not. After reset a clearing pass
// walks the set memory and writes the reset row; no access is taken during it.
// The output register holds a result while m_axis_tready is low; the sequencer stalls.
module decoupled_sectored_cache_controller_unit
  import dscc_pkg::*;
#(
  parameter int unsigned NumSets       = DefNumSets,
  parameter int unsigned NumWays       = DefNumWays,
  parameter int unsigned TagsPerWay    = DefTagsPerWay,
  parameter int unsigned SectorsPerWay = DefSectorsPerWay,
  parameter int unsigned BlockBytes    = DefBlockBytes,
  parameter int unsigned AddrWidth     = DefAddrWidth
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [AddrWidth-1:0] s_axis_tdata,   // address
  input  logic                 s_axis_tuser,   // mode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [AddrWidth-1:0] m_axis_tdata,   // request_address
  output logic [3:0]           m_axis_tuser,   // kind[1:0], miss_class[3:2]
  output logic                 m_axis_tlast    // last
);

  localparam int unsigned OB = fld_w(BlockBytes);
  localparam int unsigned SB = fld_w(SectorsPerWay);
  localparam int unsigned IB = fld_w(NumSets);
  localparam int unsigned TB = fld_w(TagsPerWay);
  localparam int unsigned SI = OB + SB;
  localparam int unsigned ST = SI + IB;
  localparam int unsigned SG = ST + TB;
  localparam int unsigned GB = (AddrWidth > SG) ? AddrWidth - SG : 0;
  localparam int unsigned GW = (GB == 0) ? 1 : GB;
  localparam int unsigned SW = idx_w(SectorsPerWay);
  localparam int unsigned IW = idx_w(NumSets);
  localparam int unsigned TW = idx_w(TagsPerWay);
  localparam int unsigned WW = idx_w(NumWays);
  localparam int unsigned NT = NumWays * TagsPerWay;
  localparam int unsigned NS = NumWays * SectorsPerWay;
  // row: tags, present, select, valid, dirty, ages
  localparam int unsigned RowW = NT * GW + NT + NS * TW + 2 * NS + NumWays * WW;

  typedef struct packed {
    logic [NumWays-1:0][TagsPerWay-1:0][GW-1:0]   tag;
    logic [NumWays-1:0][TagsPerWay-1:0]           pres;
    logic [NumWays-1:0][SectorsPerWay-1:0][TW-1:0] sel;
    logic [NumWays-1:0][SectorsPerWay-1:0]        vld;
    logic [NumWays-1:0][SectorsPerWay-1:0]        drt;
    logic [NumWays-1:0][WW-1:0]                   age;
  } row_t;

  localparam logic [2:0] StClr  = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StLook = 3'd2;
  localparam logic [2:0] StWb   = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [IW:0] clr_q, clr_d;
  logic [AddrWidth-1:0] addr_q, addr_d;
  logic mode_q, mode_d;
  row_t row_q, row_d, rd_row, rst_row;
  logic [WW-1:0] way_q, way_d;
  logic [SW:0] sk_q, sk_d;
  logic [1:0] cls_q, cls_d;
  logic o_vld_q, o_vld_d, o_last_q, o_last_d;
  logic [1:0] o_kind_q, o_kind_d, o_cls_q, o_cls_d;
  logic [AddrWidth-1:0] o_addr_q, o_addr_d;
  logic wr_en;
  logic [IW-1:0] wr_addr;
  row_t wr_row;
  logic [RowW-1:0] rd_data;

  // address fields of the held access
  logic [SW-1:0] sec;
  logic [IW-1:0] idx;
  logic [TW-1:0] at;
  logic [GW-1:0] tag;
  logic [IW-1:0] in_idx;

  function automatic logic [IW-1:0] get_idx(input logic [AddrWidth-1:0] a);
    logic [IW:0] v;
    v = '0;
    if (IB > 0) v = (IW+1)'((a >> SI) & ((AddrWidth'(1) << IB) - 1));
    if (v >= (IW+1)'(NumSets)) v = v - (IW+1)'(NumSets);
    return v[IW-1:0];
  endfunction

  always_comb begin
    logic [SW:0] s;
    logic [TW:0] t;
    s = '0;
    t = '0;
    if (SB > 0) s = (SW+1)'((addr_q >> OB) & ((AddrWidth'(1) << SB) - 1));
    if (s >= (SW+1)'(SectorsPerWay)) s = s - (SW+1)'(SectorsPerWay);
    if (TB > 0) t = (TW+1)'((addr_q >> ST) & ((AddrWidth'(1) << TB) - 1));
    if (t >= (TW+1)'(TagsPerWay)) t = t - (TW+1)'(TagsPerWay);
    sec = s[SW-1:0];
    at  = t[TW-1:0];
    idx = get_idx(addr_q);
    tag = (GB == 0) ? '0 : GW'(addr_q >> SG);
  end

  assign in_idx = get_idx(s_axis_tdata);
  assign rd_row = row_t'(rd_data);

  // reset row: ages count the ways, everything else clear
  always_comb begin
    rst_row = '0;
    for (int j = 0; j < NumWays; j++) rst_row.age[j] = WW'(j);
  end

  dscc_set_mem #(.Depth(NumSets), .Width(RowW)) u_mem (
    .clk_i,
    .rd_en_i  (s_axis_tvalid && s_axis_tready),
    .rd_addr_i(in_idx),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_row)
  );

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = o_vld_q;
  assign m_axis_tdata  = o_addr_q;
  assign m_axis_tuser  = {o_cls_q, o_kind_q};
  assign m_axis_tlast  = o_last_q;

  // sequencer
  always_comb begin
    logic hit, fnd, vfnd;
    logic [WW-1:0] hw, w, fw;
    logic match, hk;
    logic [WW-1:0] f;
    logic [TW-1:0] et;
    logic [AddrWidth-1:0] old;
    row_t r;
    state_d = state_q;
    clr_d = clr_q;
    addr_d = addr_q;
    mode_d = mode_q;
    row_d = row_q;
    way_d = way_q;
    sk_d = sk_q;
    cls_d = cls_q;
    o_vld_d = o_vld_q;
    o_last_d = o_last_q;
    o_kind_d = o_kind_q;
    o_cls_d = o_cls_q;
    o_addr_d = o_addr_q;
    wr_en = 1'b0;
    wr_addr = idx;
    wr_row = row_q;
    hit = 1'b0; fnd = 1'b0; vfnd = 1'b0;
    hw = '0; w = '0; fw = '0;
    match = 1'b0; hk = 1'b0;
    f = '0; et = '0; old = '0;
    r = row_q;

    if (o_vld_q && m_axis_tready) o_vld_d = 1'b0;

    unique case (state_q)
      StClr: begin
        wr_en = 1'b1;
        wr_addr = clr_q[IW-1:0];
        wr_row = rst_row;
        clr_d = clr_q + 1'b1;
        if (clr_q == (IW+1)'(NumSets - 1)) state_d = StIdle;
      end
      StIdle: begin
        if (s_axis_tvalid) begin
          addr_d = s_axis_tdata;
          mode_d = s_axis_tuser;
          state_d = StLook;
        end
      end
      StLook: begin
        r = rd_row;
        row_d = rd_row;
        for (int j = NumWays - 1; j >= 0; j--) begin
          if (r.pres[j][at] && r.tag[j][at] == tag && r.sel[j][sec] == at && r.vld[j][sec]) begin
            hit = 1'b1; hw = WW'(j);
          end
        end
        for (int j = NumWays - 1; j >= 0; j--) begin
          if (!r.pres[j][at] && !r.vld[j][sec]) begin
            vfnd = 1'b1; fw = WW'(j);
          end
        end
        for (int j = NumWays - 1; j >= 0; j--) begin
          if (r.pres[j][at] && r.tag[j][at] == tag && !r.vld[j][sec]) begin
            fnd = 1'b1; fw = WW'(j);
          end
        end
        fnd = fnd | vfnd;
        w = '0;
        for (int j = NumWays - 1; j >= 0; j--)
          if (r.age[j] == WW'(NumWays - 1)) w = WW'(j);
        if (hit) w = hw;
        else if (fnd) w = fw;
        way_d = w;
        cls_d = (|r.vld[w]) ? ClassBlock : ClassSector;
        sk_d = '0;
        if (hit || fnd) state_d = StOut;
        else state_d = StWb;
      end
      StWb: begin
        // one sector per cycle of the evicted way, while the output register is free or taken
        if (!o_vld_q || m_axis_tready) begin
          w = way_q;
          match = row_q.pres[w][at] && row_q.tag[w][at] == tag;
          hk = match ? (sk_q[SW-1:0] == sec)
                     : (row_q.vld[w][sk_q[SW-1:0]] &&
                        (row_q.sel[w][sk_q[SW-1:0]] == at || sk_q[SW-1:0] == sec));
          if (hk) begin
            if (row_q.vld[w][sk_q[SW-1:0]] && row_q.drt[w][sk_q[SW-1:0]]) begin
              et = row_q.sel[w][sk_q[SW-1:0]];
              old = (AddrWidth'(row_q.tag[w][et]) << SG) | (AddrWidth'(et) << ST) |
                    (AddrWidth'(idx) << SI) | (AddrWidth'(sk_q[SW-1:0]) << OB);
              if (GB == 0) old = (AddrWidth'(et) << ST) | (AddrWidth'(idx) << SI) |
                                 (AddrWidth'(sk_q[SW-1:0]) << OB);
              o_vld_d = 1'b1; o_kind_d = KindWb; o_addr_d = old;
              o_cls_d = ClassNone; o_last_d = 1'b0;
            end
            row_d.vld[w][sk_q[SW-1:0]] = 1'b0;
            row_d.drt[w][sk_q[SW-1:0]] = 1'b0;
            if (!match) row_d.sel[w][sk_q[SW-1:0]] = '0;
          end
          sk_d = sk_q + 1'b1;
          if (sk_q == (SW+1)'(SectorsPerWay - 1)) begin
            // evicted fill always sets dirty to mode
            row_d.drt[w][sec] = 1'b0;
            state_d = StOut;
          end
        end
      end
      StOut: begin
        if (!o_vld_q || m_axis_tready) begin
          w = way_q;
          r = row_q;
          hit = r.pres[w][at] && r.tag[w][at] == tag && r.sel[w][sec] == at && r.vld[w][sec];
          if (!hit) begin
            r.tag[w][at] = tag;
            r.pres[w][at] = 1'b1;
            r.sel[w][sec] = at;
            r.vld[w][sec] = 1'b1;
          end
          if (mode_q) r.drt[w][sec] = 1'b1;
          f = row_q.age[w];
          for (int j = 0; j < NumWays; j++) begin
            if (row_q.age[j] < f) r.age[j] = row_q.age[j] + 1'b1;
            else if (row_q.age[j] == f) r.age[j] = '0;
          end
          wr_en = 1'b1;
          wr_row = r;
          o_vld_d = 1'b1;
          o_last_d = 1'b1;
          o_kind_d = hit ? KindHit : KindFill;
          o_addr_d = hit ? '0 : addr_q;
          o_cls_d = hit ? ClassNone : cls_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      clr_q <= '0;
      o_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      o_vld_q <= o_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    mode_q <= mode_d;
    row_q <= row_d;
    way_q <= way_d;
    sk_q <= sk_d;
    cls_q <= cls_d;
    o_last_q <= o_last_d;
    o_kind_q <= o_kind_d;
    o_cls_q <= o_cls_d;
    o_addr_q <= o_addr_d;
  end

  // a held result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q && !m_axis_tready |=> o_vld_q && $stable(o_addr_q)) else $error("result lost");
  // no access is taken during the clearing pass
  a_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StClr |-> !s_axis_tready) else $error("accept during clear");
  // a hit never carries an address
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q && o_kind_q == KindHit |-> o_addr_q == '0 && o_last_q) else $error("bad hit");
  // write-backs are never the last result
  a_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o_vld_q && o_kind_q == KindWb |-> !o_last_q) else $error("bad write-back");

endmodule

### bench/tb.sv
// Testbench for decoupled_sectored_cache_controller_unit: directed and random accesses,
// checked against a behavioral cache model. Depends on dscc_pkg and the RTL.
module tb;
  import dscc_pkg::*;

  localparam int unsigned Sets = 64;
  localparam int unsigned Ways = 4;
  localparam int unsigned Tags = 2;
  localparam int unsigned Secs = 4;
  localparam int unsigned OffB = 5;
  localparam int unsigned SecB = 2;
  localparam int unsigned SetB = 6;
  localparam int unsigned SlotB = 1;
  localparam int unsigned SetLo = OffB + SecB;
  localparam int unsigned SlotLo = SetLo + SetB;
  localparam int unsigned TagLo = SlotLo + SlotB;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] req_addr;
    logic [1:0]  cls;
    logic        last;
  } cache_result_t;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;

  decoupled_sectored_cache_controller_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  // cache shadow state
  logic [17:0] tag_mem [Sets*Ways*Tags];
  logic        tag_used [Sets*Ways*Tags];
  logic        sec_sel [Sets*Ways*Secs];
  logic        sec_vld [Sets*Ways*Secs];
  logic        sec_dty [Sets*Ways*Secs];
  logic [1:0]  age [Sets*Ways];

  cache_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 0;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int block_class(int w);
    for (int k = 0; k < Secs; k++) if (sec_vld[w*Secs+k]) return 1;
    return 2;
  endfunction

  function automatic void age_update(int set, int w);
    logic [1:0] f;
    f = age[w];
    for (int j = 0; j < Ways; j++) begin
      if (age[set*Ways+j] < f) age[set*Ways+j]++;
      else if (age[set*Ways+j] == f) age[set*Ways+j] = 0;
    end
  endfunction

  function automatic void push_result(logic [1:0] k, logic [31:0] a, logic [1:0] c, logic l);
    cache_result_t r;
    r.kind = k; r.req_addr = a; r.cls = c; r.last = l;
    pending_results.push_back(r);
  endfunction

  // predict the results of one access and update the shadow state
  function automatic void predict_access(logic wr, logic [31:0] a);
    int sec, set, slot, w, ts, ss, cls, s, found;
    logic [17:0] tg;
    logic match, take;
    logic [31:0] old;
    sec = int'(a[SetLo-1:OffB]); set = int'(a[SlotLo-1:SetLo]);
    slot = int'(a[TagLo-1:SlotLo]);
    tg = a[31:TagLo];
    for (int j = 0; j < Ways; j++) begin
      w = set*Ways+j; ts = w*Tags+slot; ss = w*Secs+sec;
      if (tag_used[ts] && tag_mem[ts] == tg && sec_sel[ss] == slot && sec_vld[ss]) begin
        if (wr) sec_dty[ss] = 1;
        age_update(set, w);
        push_result(KindHit, 0, ClassNone, 1);
        return;
      end
    end
    found = -1;
    for (int j = 0; j < Ways && found < 0; j++) begin
      w = set*Ways+j; ts = w*Tags+slot; ss = w*Secs+sec;
      if (tag_used[ts] && tag_mem[ts] == tg && !sec_vld[ss]) found = w;
    end
    for (int j = 0; j < Ways && found < 0; j++) begin
      w = set*Ways+j; ts = w*Tags+slot; ss = w*Secs+sec;
      if (!tag_used[ts] && !sec_vld[ss]) found = w;
    end
    if (found >= 0) begin
      w = found; ts = w*Tags+slot; ss = w*Secs+sec;
      cls = block_class(w);
      tag_mem[ts] = tg; tag_used[ts] = 1; sec_sel[ss] = slot[0]; sec_vld[ss] = 1;
      if (wr) sec_dty[ss] = 1;
      age_update(set, w);
      push_result(KindFill, a, cls[1:0], 1);
      return;
    end
    // evict the oldest way, way 0 when no way holds the top age
    w = set*Ways;
    for (int j = Ways-1; j >= 0; j--) if (age[set*Ways+j] == Ways-1) w = set*Ways+j;
    ts = w*Tags+slot; ss = w*Secs+sec;
    cls = block_class(w);
    match = tag_used[ts] && tag_mem[ts] == tg;
    for (int k = 0; k < Secs; k++) begin
      s = w*Secs+k;
      take = match ? (k == sec) : (sec_vld[s] && (sec_sel[s] == slot || k == sec));
      if (take) begin
        if (sec_vld[s] && sec_dty[s]) begin
          old = {tag_mem[w*Tags+sec_sel[s]], sec_sel[s], set[SetB-1:0], k[SecB-1:0],
                 {OffB{1'b0}}};
          push_result(KindWb, old, ClassNone, 0);
        end
        sec_vld[s] = 0; sec_dty[s] = 0;
        if (!match) sec_sel[s] = 0;
      end
    end
    tag_mem[ts] = tg; tag_used[ts] = 1; sec_sel[ss] = slot[0]; sec_vld[ss] = 1;
    sec_dty[ss] = wr;
    age_update(set, w);
    push_result(KindFill, a, cls[1:0], 1);
  endfunction

  // random gap, mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one access; predict on transfer
  task automatic send_access(logic wr, logic [31:0] a);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1; s_axis_tdata <= a; s_axis_tuser <= wr;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_access(wr, a);
  endtask

  // receiver stall pattern
  initial begin
    int g;
    m_axis_tready = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) m_axis_tready <= 0;
      else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 0;
        g = gap_len() + 1;
        repeat (g) @(posedge clk_i);
        m_axis_tready <= 1;
      end else m_axis_tready <= 1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    cache_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result addr=%h", m_axis_tdata);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.kind !== m_axis_tuser[1:0] || exp_r.req_addr !== m_axis_tdata ||
            exp_r.cls !== m_axis_tuser[3:2] || exp_r.last !== m_axis_tlast) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp k=%0d a=%h c=%0d l=%0d got k=%0d a=%h c=%0d l=%0d",
                     exp_r.kind, exp_r.req_addr, exp_r.cls, exp_r.last, m_axis_tuser[1:0],
                     m_axis_tdata, m_axis_tuser[3:2], m_axis_tlast);
        end
      end
    end
  end

  function automatic logic [31:0] make_addr(int tg, int slot, int set, int sec);
    return {tg[17:0], slot[0], set[5:0], sec[1:0], 5'($urandom)};
  endfunction

  task automatic test_directed();
    send_access(0, 32'h0000_0000);
    send_access(1, 32'hFFFF_FFFF);
    send_access(0, 32'h0000_0000);          // hit
    send_access(1, 32'h0000_0004);          // write hit
    send_access(0, make_addr(0, 0, 0, 1));  // tag match, invalid sector
    send_access(1, make_addr(0, 1, 0, 2));  // other slot
    // fill set 5 past its ways so the oldest way is evicted with dirty sectors
    for (int t = 1; t <= 6; t++) begin
      send_access(1, make_addr(t, 0, 5, 0));
      send_access(1, make_addr(t, 0, 5, 1));
    end
    send_access(1, make_addr(3, 0, 5, 2));  // victim slot tag match
    send_access(0, make_addr(9, 1, 5, 3));
    send_access(0, make_addr(10, 0, 5, 0));
    send_access(1, 32'hAAAA_AAAA);
    send_access(0, 32'h5555_5555);
  endtask

  // random accesses, mostly over a small address pool so hits and evictions recur
  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_access(1'($urandom), $urandom);
      else send_access(1'($urandom), make_addr($urandom_range(0, 5), $urandom_range(0, 1),
                                               $urandom_range(0, 3), $urandom_range(0, 3)));
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      test_random(20);
    join
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < Sets*Ways*Tags; i++) begin tag_mem[i] = 0; tag_used[i] = 0; end
    for (int i = 0; i < Sets*Ways*Secs; i++) begin
      sec_sel[i] = 0; sec_vld[i] = 0; sec_dty[i] = 0;
    end
    for (int i = 0; i < Sets*Ways; i++) age[i] = 2'(i % Ways);
    rst_ni = 0; s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    test_directed();
    test_random(200);
    test_backpressure();
    test_random(170);
    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
rtl/dscc_pkg.sv
rtl/dscc_set_mem.sv
rtl/decoupled_sectored_cache_controller_unit.sv
bench/tb.sv
